@@ hdl/spoq_pkg.sv @@
package spoq_pkg;

   localparam int TAG_W      = 16;
   localparam int YEAR_W     = 12;
   localparam int PRIO_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int REMAIN_W   = 5;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   localparam logic [YEAR_W-1:0] YEAR_RESET   = 12'd2021;
   localparam logic [YEAR_W-1:0] WINDOW_RESET = 12'd6;

   localparam logic [PRIO_W-1:0] PRIO_EXPRESS = 2'd3;
   localparam logic [PRIO_W-1:0] PRIO_RECENT  = 2'd2;
   localparam logic [PRIO_W-1:0] PRIO_OLD     = 2'd1;

   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SERVED   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd3;

   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_SERVICE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_YEAR  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECENT_WINDOW = 4'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } slot_type;

endpackage

@@ hdl/spoq_if.sv @@
interface spoq_req_if import spoq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [TAG_W-1:0]  order_tag;
   logic [YEAR_W-1:0] model_year;
   logic              express;

   modport source (output valid, kind, order_tag, model_year, express, input ready);
   modport sink (input valid, kind, order_tag, model_year, express, output ready);
endinterface

interface spoq_rsp_if import spoq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TAG_W-1:0]    served_tag;
   logic [PRIO_W-1:0]   served_priority;
   logic [REMAIN_W-1:0] remaining;

   modport source (output valid, status, served_tag, served_priority, remaining,
                   input ready);
   modport sink (input valid, status, served_tag, served_priority, remaining,
                 output ready);
endinterface

interface spoq_csr_if import spoq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/stable_priority_order_queue.sv @@
// Stable priority queue of orders, up to ENTRIES deep.
// req_bus: one beat per command. kind 0 enqueues order_tag with a priority of
//   3 (express), 2 (recent or future model year) or 1 (older). kind 1 serves
//   the earliest held order of highest priority and closes the gap behind it.
// rsp_bus: exactly one beat per command, carrying status, the served order
//   (zero unless served) and the count left in the queue.
// csr_bus: register 0 current_year, register 1 recent_window; always ready.
//   The user must write them only while the queue is idle; this is not enforced.
// Sequence: an enqueue, a rejected enqueue and a service of an empty queue go
//   from accept to ST_FINISH, which loads the response register. A service of a
//   queue with the winner at slot b first scans each held slot through the shared
//   priority comparator (ST_SCAN), then moves each slot behind b down one place
//   through the single read and write port of the slot memory (ST_SHIFT).
// req_bus.ready is high only while the sequencer is idle; one command at a time.
// A finished response waits in the output register while the next command is
// taken; the sequencer holds its result when rsp_bus.ready stays low.
// Reset empties the queue and restores current_year 2021, recent_window 6.
module stable_priority_order_queue import spoq_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   spoq_req_if.sink   req_bus,
   spoq_rsp_if.source rsp_bus,
   spoq_csr_if.sink   csr_bus
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FW = $clog2(ENTRIES + 1);
   localparam logic [FW-1:0] FILL_MAX = FW'(ENTRIES);

   state_type state_ff, state_in;

   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [YEAR_W-1:0]   window_ff, window_in;
   logic [FW-1:0]       fill_ff, fill_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       best_idx_ff, best_idx_in;
   logic [TAG_W-1:0]    best_tag_ff, best_tag_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic [PRIO_W-1:0]   res_prio_ff, res_prio_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic [PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;
   logic [REMAIN_W-1:0] rsp_remain_ff, rsp_remain_in;

   slot_type            slot_mem [ENTRIES];
   slot_type            rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   slot_type            wr_data;

   logic                req_fire;
   logic                out_free;
   logic                is_full;
   logic                is_empty;
   logic                last_scan;
   logic                take;
   logic                more_shift;
   logic [AW-1:0]       best_idx_sel;
   logic [PRIO_W-1:0]   new_prio;
   logic [YEAR_W-1:0]   age;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign is_full  = (fill_ff >= FILL_MAX);
   assign is_empty = (fill_ff == '0);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.served_tag      = rsp_tag_ff;
   assign rsp_bus.served_priority = rsp_prio_ff;
   assign rsp_bus.remaining       = rsp_remain_ff;

   assign age = year_ff - req_bus.model_year;

   always_comb begin
      if (req_bus.express) begin
         new_prio = PRIO_EXPRESS;
      end else if (req_bus.model_year > year_ff) begin
         new_prio = PRIO_RECENT;
      end else if (age < window_ff) begin
         new_prio = PRIO_RECENT;
      end else begin
         new_prio = PRIO_OLD;
      end
   end

   // shared comparator: one slot per cycle against the running best
   assign take         = (idx_ff == '0) || (rd_data_ff.prio > best_prio_ff);
   assign best_idx_sel = take ? idx_ff : best_idx_ff;
   assign last_scan    = ((FW'(idx_ff) + FW'(1)) == fill_ff);
   assign more_shift   = ((FW'(idx_ff) + FW'(1)) < fill_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.kind == KIND_SERVICE && !is_empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (last_scan) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (!more_shift) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      best_idx_in   = best_idx_ff;
      best_tag_in   = best_tag_ff;
      best_prio_in  = best_prio_ff;
      res_status_in = res_status_ff;
      res_tag_in    = res_tag_ff;
      res_prio_in   = res_prio_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[AW-1:0];
      wr_data       = '{prio: new_prio, tag: req_bus.order_tag};
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_remain_in = rsp_remain_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in     = '0;
            res_tag_in = '0;
            res_prio_in = '0;
            if (req_fire) begin
               if (req_bus.kind == KIND_ENQUEUE) begin
                  if (is_full) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en         = 1'b1;
                     fill_in       = fill_ff + FW'(1);
                     res_status_in = STATUS_ENQUEUED;
                  end
               end else if (is_empty) begin
                  res_status_in = STATUS_EMPTY;
               end
            end
         end
         ST_SCAN: begin
            best_idx_in = best_idx_sel;
            if (take) begin
               best_tag_in  = rd_data_ff.tag;
               best_prio_in = rd_data_ff.prio;
            end
            if (last_scan) begin
               idx_in  = best_idx_sel;
               rd_addr = best_idx_sel + AW'(1);
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         ST_SHIFT: begin
            if (more_shift) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data_ff;
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(2);
            end else begin
               fill_in       = fill_ff - FW'(1);
               res_status_in = STATUS_SERVED;
               res_tag_in    = best_tag_ff;
               res_prio_in   = best_prio_ff;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_prio_in   = res_prio_ff;
               rsp_remain_in = REMAIN_W'(fill_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      year_in   = year_ff;
      window_in = window_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_CURRENT_YEAR:  year_in   = csr_bus.data;
            CSR_RECENT_WINDOW: window_in = csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         year_ff      <= YEAR_RESET;
         window_ff    <= WINDOW_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         year_ff      <= year_in;
         window_ff    <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_tag_ff   <= best_tag_in;
      best_prio_ff  <= best_prio_in;
      res_status_ff <= res_status_in;
      res_tag_ff    <= res_tag_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_remain_ff <= rsp_remain_in;
   end

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_MAX)
      else $error("fill count above capacity");

   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> FW'(idx_ff) < fill_ff)
      else $error("scan index beyond held orders");

   a_shift_nonempty : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> fill_ff != '0)
      else $error("compaction on empty queue");

   a_enqueue_grows : assert property (@(posedge clock) disable iff (reset)
      req_fire && req_bus.kind == KIND_ENQUEUE && !is_full
      |=> fill_ff == $past(fill_ff) + FW'(1))
      else $error("accepted enqueue did not grow queue");

   a_served_prio : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT && !more_shift |-> best_prio_ff != '0)
      else $error("served order without priority");

endmodule

@@ tb/tb_stable_priority_order_queue.sv @@
module tb_stable_priority_order_queue import spoq_pkg::*; ();

   localparam int QUEUE_DEPTH = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int ROWS = 25;
   localparam longint LIMIT_TIME = 2_000_000;

   typedef struct packed {
      logic              kind;
      logic [TAG_W-1:0]  tag;
      logic [YEAR_W-1:0] year;
      logic              express;
   } command_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    tag;
      logic [PRIO_W-1:0]   prio;
      logic [REMAIN_W-1:0] remaining;
   } reply_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } held_order_type;

   typedef struct packed {
      command_type cmd;
      logic        typed;
      reply_type   reply;
   } directed_row_type;

   localparam reply_type NO_REPLY = '0;

   logic clock;
   logic reset;

   spoq_req_if req_bus ();
   spoq_rsp_if rsp_bus ();
   spoq_csr_if csr_bus ();

   stable_priority_order_queue #(.ENTRIES(QUEUE_DEPTH)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // queue model and its own copy of the registers
   held_order_type    held_orders [$];
   reply_type         expected_replies [$];
   logic [YEAR_W-1:0] year_now;
   logic [YEAR_W-1:0] window_len;
   int                mismatch_count;
   bit                quiet_phase;
   bit                hold_request;

   int year_plan [PHASES]   = '{2021, 0, 4095, 4095, 0, 2048, 0, 0};
   int window_plan [PHASES] = '{6, 0, 4095, 0, 4095, 1, 0, 0};

   // default registers: year 2021, window 6
   directed_row_type directed_rows [ROWS] = '{
      '{'{KIND_SERVICE, 16'h0000, 12'd0, 1'b0}, 1'b1, '{STATUS_EMPTY, 16'h0, 2'd0, 5'd0}},
      '{'{KIND_ENQUEUE, 16'hFFFF, 12'd2021, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0000, 12'd0, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h1234, 12'd4095, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'hABCD, 12'd2015, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h5A5A, 12'd2016, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h8001, 12'd0, 1'b1}, 1'b0, NO_REPLY},
      '{'{KIND_SERVICE, 16'hFFFF, 12'd4095, 1'b1}, 1'b0, NO_REPLY},
      '{'{KIND_SERVICE, 16'h0000, 12'd0, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_SERVICE, 16'h0000, 12'd0, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h7FFF, 12'd2022, 1'b1}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0100, 12'd2020, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0101, 12'd2000, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0102, 12'd2020, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0103, 12'd2000, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0104, 12'd3000, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0105, 12'd100, 1'b1}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0106, 12'd2019, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0107, 12'd1, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0108, 12'd2021, 1'b1}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h0109, 12'd2015, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h010A, 12'd2016, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'h010B, 12'd2022, 1'b0}, 1'b0, NO_REPLY},
      '{'{KIND_ENQUEUE, 16'hC0DE, 12'd2021, 1'b1}, 1'b1, '{STATUS_FULL, 16'h0, 2'd0, 5'd16}},
      '{'{KIND_SERVICE, 16'h0000, 12'd0, 1'b0}, 1'b0, NO_REPLY}
   };

   function automatic logic [PRIO_W-1:0] order_rank(logic [YEAR_W-1:0] year, logic express);
      if (express)
         return PRIO_EXPRESS;
      if (year > year_now)
         return PRIO_RECENT;
      return ((year_now - year) < window_len) ? PRIO_RECENT : PRIO_OLD;
   endfunction

   function automatic reply_type run_command(command_type cmd);
      reply_type      r;
      held_order_type slot;
      int             best;
      r = '0;
      if (cmd.kind == KIND_ENQUEUE) begin
         if (held_orders.size() >= QUEUE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            slot.prio = order_rank(cmd.year, cmd.express);
            slot.tag = cmd.tag;
            held_orders = {held_orders, slot};
            r.status = STATUS_ENQUEUED;
         end
      end else if (held_orders.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         best = 0;
         for (int i = 1; i < held_orders.size(); i++)
            if (held_orders[i].prio > held_orders[best].prio)
               best = i;
         r.tag = held_orders[best].tag;
         r.prio = held_orders[best].prio;
         held_orders.delete(best);
         r.status = STATUS_SERVED;
      end
      r.remaining = REMAIN_W'(held_orders.size());
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_phase)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // entered at a falling edge, returns at the falling edge after the beat
   task automatic send_command(command_type cmd, logic typed, reply_type typed_reply);
      int        gap;
      reply_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= cmd.kind;
      req_bus.order_tag <= cmd.tag;
      req_bus.model_year <= cmd.year;
      req_bus.express <= cmd.express;
      do @(posedge clock); while (req_bus.valid !== 1'b1 || req_bus.ready !== 1'b1);
      predicted = run_command(cmd);
      if (typed)
         predicted = typed_reply;
      expected_replies = {expected_replies, predicted};
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.valid !== 1'b1 || csr_bus.ready !== 1'b1);
      if (index == CSR_CURRENT_YEAR)
         year_now = value;
      else if (index == CSR_RECENT_WINDOW)
         window_len = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(LIMIT_TIME);
      $display("tb_stable_priority_order_queue: done, errors");
      $finish;
   end

   // result side: random ready runs, one long hold-off on request
   initial begin : response_pacing
      int run_left;
      int hold_left;
      run_left = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
         end else if (quiet_phase || $urandom_range(0, 3) != 0) begin
            rsp_bus.ready <= 1'b1;
            run_left = quiet_phase ? 0 : $urandom_range(0, 6);
         end else begin
            rsp_bus.ready <= 1'b0;
            run_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : response_check
      reply_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_replies.size() == 0) begin
            $error("response beat with nothing outstanding");
            mismatch_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("served_tag", want.tag, rsp_bus.served_tag);
            check_field("served_priority", want.prio, rsp_bus.served_priority);
            check_field("remaining", want.remaining, rsp_bus.remaining);
         end
      end
   end

   initial begin : stimulus
      command_type cmd;
      int          bias;
      int          age;
      mismatch_count = 0;
      quiet_phase = 1'b0;
      hold_request = 1'b0;
      year_now = YEAR_RESET;
      window_len = WINDOW_RESET;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_ENQUEUE;
      req_bus.order_tag = '0;
      req_bus.model_year = '0;
      req_bus.express = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_CURRENT_YEAR;
      csr_bus.data = '0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].reply);

      bias = 50;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p >= PHASES - 2) begin
            year_plan[p] = $urandom_range(0, 4095);
            window_plan[p] = (p == PHASES - 1) ? $urandom_range(0, 4095) : $urandom_range(0, 20);
         end
         write_register(CSR_CURRENT_YEAR, CSR_DATA_W'(year_plan[p]));
         write_register(CSR_RECENT_WINDOW, CSR_DATA_W'(window_plan[p]));
         quiet_phase = (p == 5);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // every 20 commands pick a fill, drain or even bias so both full and empty are reached
            if (n % 20 == 0) begin
               case ($urandom_range(0, 2))
                  0: bias = 85;
                  1: bias = 15;
                  default: bias = 50;
               endcase
            end
            if (p == 2 && n == 10)
               hold_request = 1'b1;
            cmd.kind = ($urandom_range(0, 99) < bias) ? KIND_ENQUEUE : KIND_SERVICE;
            cmd.tag = TAG_W'($urandom);
            cmd.express = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 4))
               0: begin
                  age = int'(window_len) + $urandom_range(0, 2) - 1;
                  cmd.year = YEAR_W'(int'(year_now) - age);
               end
               1: cmd.year = YEAR_W'(int'(year_now) - $urandom_range(0, 8));
               2: cmd.year = YEAR_W'(int'(year_now) + $urandom_range(1, 4));
               3: cmd.year = YEAR_W'($urandom);
               default: cmd.year = $urandom_range(0, 1) ? '1 : '0;
            endcase
            send_command(cmd, 1'b0, NO_REPLY);
         end
      end
      quiet_phase = 1'b0;

      drain();
      if (mismatch_count == 0)
         $display("tb_stable_priority_order_queue: done, clean");
      else
         $display("tb_stable_priority_order_queue: done, errors");
      $finish;
   end

endmodule
